[hdl/assert_macros.svh]
// Assertion macros used by the checker file, ifc_checker.sv.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hdl/ifc_pkg.sv]
// Shared types, codes and helpers for the instruction frequency counter.
// No dependencies.
package ifc_pkg;

  // request types
  localparam logic [2:0] REQ_OPCODE = 3'd0;
  localparam logic [2:0] REQ_CONST  = 3'd1;
  localparam logic [2:0] REQ_LREAD  = 3'd2;
  localparam logic [2:0] REQ_LWRITE = 3'd3;
  localparam logic [2:0] REQ_LTEE   = 3'd4;
  localparam logic [2:0] REQ_LOAD   = 3'd5;
  localparam logic [2:0] REQ_STORE  = 3'd6;
  localparam logic [2:0] REQ_READ   = 3'd7;

  // read table selector
  localparam logic [2:0] RT_OPCODES = 3'd0;
  localparam logic [2:0] RT_STORES  = 3'd6;

  // result status codes
  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_IGNORED = 3'd3;
  localparam logic [2:0] ST_READ    = 3'd4;

  // request classes seen by the controller
  localparam logic [2:0] CLS_OPCODE = 3'd0;
  localparam logic [2:0] CLS_IGNORE = 3'd1;
  localparam logic [2:0] CLS_KEY    = 3'd2;
  localparam logic [2:0] CLS_RD_OP  = 3'd3;
  localparam logic [2:0] CLS_RD_ENT = 3'd4;
  localparam logic [2:0] CLS_RD_NONE = 3'd5;

  // result forms
  localparam logic [2:0] OUT_OPCNT  = 3'd0;
  localparam logic [2:0] OUT_IGN    = 3'd1;
  localparam logic [2:0] OUT_HIT    = 3'd2;
  localparam logic [2:0] OUT_NEW    = 3'd3;
  localparam logic [2:0] OUT_FULL   = 3'd4;
  localparam logic [2:0] OUT_RDOP   = 3'd5;
  localparam logic [2:0] OUT_RDENT  = 3'd6;
  localparam logic [2:0] OUT_RDNONE = 3'd7;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       idx_clr;
    logic       idx_inc;
    logic       op_wr;
    logic       ent_rd_user;
    logic       ent_wr_hit;
    logic       ent_wr_new;
    logic       emit;
    logic [2:0] out_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] cls;
    logic       fill_zero;
    logic       match;
    logic       last;
    logic       full;
  } sts_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + 32'd1;
  endfunction

endpackage

[hdl/ifc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ifc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/ifc_ctrl.sv]
// Sequencer for the instruction frequency counter.
// Depends on ifc_pkg for the command and status structs and codes.
module ifc_ctrl import ifc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_OP_UPD = 3'd2;
  localparam logic [2:0] S_K_RD   = 3'd3;
  localparam logic [2:0] S_K_CMP  = 3'd4;
  localparam logic [2:0] S_MISS   = 3'd5;
  localparam logic [2:0] S_RD_OP  = 3'd6;
  localparam logic [2:0] S_RD_ENT = 3'd7;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        case (sts.cls)
          CLS_OPCODE: state_next = S_OP_UPD;
          CLS_KEY: begin
            cmd.idx_clr = 1'b1;
            state_next  = sts.fill_zero ? S_MISS : S_K_RD;
          end
          CLS_RD_OP: state_next = S_RD_OP;
          CLS_RD_ENT: begin
            cmd.ent_rd_user = 1'b1;
            state_next      = S_RD_ENT;
          end
          CLS_RD_NONE: begin
            cmd.emit    = 1'b1;
            cmd.out_sel = OUT_RDNONE;
            state_next  = S_IDLE;
          end
          default: begin
            cmd.emit    = 1'b1;
            cmd.out_sel = OUT_IGN;
            state_next  = S_IDLE;
          end
        endcase
      end
      S_OP_UPD: begin
        cmd.op_wr   = 1'b1;
        cmd.emit    = 1'b1;
        cmd.out_sel = OUT_OPCNT;
        state_next  = S_IDLE;
      end
      S_K_RD: begin
        state_next = S_K_CMP;
      end
      S_K_CMP: begin
        if (sts.match) begin
          cmd.ent_wr_hit = 1'b1;
          cmd.emit       = 1'b1;
          cmd.out_sel    = OUT_HIT;
          state_next     = S_IDLE;
        end else if (sts.last) begin
          state_next = S_MISS;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_K_RD;
        end
      end
      S_MISS: begin
        cmd.emit = 1'b1;
        if (sts.full) begin
          cmd.out_sel = OUT_FULL;
        end else begin
          cmd.ent_wr_new = 1'b1;
          cmd.out_sel    = OUT_NEW;
        end
        state_next = S_IDLE;
      end
      S_RD_OP: begin
        cmd.emit    = 1'b1;
        cmd.out_sel = OUT_RDOP;
        state_next  = S_IDLE;
      end
      S_RD_ENT: begin
        cmd.emit    = 1'b1;
        cmd.out_sel = OUT_RDENT;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hdl/ifc_dpath.sv]
// Datapath: request latch, config registers, histogram and key tables,
// fill levels and the result register. Depends on ifc_pkg and ifc_ram.
module ifc_dpath import ifc_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int OPCODE_SLOTS  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic [2:0]  req_type,
  input  logic [7:0]  opcode,
  input  logic [31:0] key_value,
  input  logic [4:0]  align_log2,
  input  logic [31:0] mem_offset,
  input  logic [2:0]  read_table,
  input  logic [7:0]  read_index,
  input  cmd_t        cmd,
  output sts_t        sts,
  output logic        done,
  output logic [2:0]  status,
  output logic        entry_valid,
  output logic [31:0] first_key,
  output logic [31:0] second_key,
  output logic [31:0] hit_count,
  output logic [8:0]  fill_level
);

  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int FW  = $clog2(TABLE_ENTRIES + 1);
  localparam int OW  = $clog2(OPCODE_SLOTS);
  localparam int ED  = 6 * TABLE_ENTRIES;
  localparam int EAW = $clog2(ED);
  localparam int EW  = 69;

  // latched request
  logic [2:0]  q_req;
  logic [7:0]  q_op;
  logic [31:0] q_key;
  logic [4:0]  q_al;
  logic [31:0] q_off;
  logic [2:0]  q_rt;
  logic [7:0]  q_ri;

  logic [7:0] load_match, store_match;
  logic [8:0] extent;
  logic [OPCODE_SLOTS-1:0] op_valid;
  logic [FW-1:0] fill [6];
  logic [IW-1:0] idx;

  logic [2:0]     tbl;
  logic [2:0]     cls;
  logic           pair;
  logic [FW-1:0]  sel_fill;
  logic [31:0]    kv;
  logic [4:0]     al;
  logic [7:0]     op_sel;
  logic [OW-1:0]  op_addr;
  logic [31:0]    op_rdata, op_cur, op_inc;
  logic           ext_grow;
  logic [8:0]     ext_new;
  logic [EAW-1:0] base, scan_addr, user_addr, new_addr, ent_raddr, ent_waddr;
  logic [EW-1:0]  ent_rdata, ent_wdata;
  logic [4:0]     rd_al;
  logic [31:0]    rd_key, rd_cnt, ent_inc;
  logic           ent_we;
  logic [8:0]     fill9, rdnone_fill;

  // table select: 0..3 single-key tables, 4..5 pair tables
  always_comb begin
    case (q_req)
      REQ_CONST, REQ_LREAD, REQ_LWRITE, REQ_LTEE: tbl = q_req - 3'd1;
      REQ_LOAD:  tbl = 3'd4;
      REQ_STORE: tbl = 3'd5;
      default: begin
        if (q_rt != RT_OPCODES && q_rt <= RT_STORES) begin
          tbl = q_rt - 3'd1;
        end else begin
          tbl = 3'd0;
        end
      end
    endcase
  end

  assign pair     = (tbl >= 3'd4);
  assign sel_fill = fill[tbl];
  assign fill9    = 9'(sel_fill);
  assign kv       = pair ? q_off : q_key;
  assign al       = pair ? q_al : 5'd0;

  // request class
  always_comb begin
    case (q_req)
      REQ_OPCODE: begin
        cls = ({1'b0, q_op} < 9'(OPCODE_SLOTS)) ? CLS_OPCODE : CLS_IGNORE;
      end
      REQ_CONST, REQ_LREAD, REQ_LWRITE, REQ_LTEE: cls = CLS_KEY;
      REQ_LOAD:  cls = (q_op == load_match) ? CLS_KEY : CLS_IGNORE;
      REQ_STORE: cls = (q_op == store_match) ? CLS_KEY : CLS_IGNORE;
      default: begin
        if (q_rt == RT_OPCODES) begin
          cls = ({1'b0, q_ri} < extent && {1'b0, q_ri} < 9'(OPCODE_SLOTS))
                ? CLS_RD_OP : CLS_RD_NONE;
        end else if (q_rt <= RT_STORES) begin
          cls = ({1'b0, q_ri} < fill9) ? CLS_RD_ENT : CLS_RD_NONE;
        end else begin
          cls = CLS_RD_NONE;
        end
      end
    endcase
  end

  assign sts.cls = cls;

  // opcode histogram
  assign op_sel  = (q_req == REQ_READ) ? q_ri : q_op;
  assign op_addr = op_sel[OW-1:0];
  assign op_cur  = op_valid[op_addr] ? op_rdata : 32'd0;
  assign op_inc  = sat_inc(op_cur);
  assign ext_grow = ({1'b0, q_op} >= extent);
  assign ext_new  = ext_grow ? ({1'b0, q_op} + 9'd1) : extent;

  ifc_ram #(.WIDTH(32), .DEPTH(OPCODE_SLOTS)) u_op_ram (
    .clk   (clk),
    .we    (cmd.op_wr),
    .waddr (op_addr),
    .wdata (op_inc),
    .raddr (op_addr),
    .rdata (op_rdata)
  );

  // key tables: one RAM, rows of {align, key, count}
  assign base      = EAW'(tbl) * EAW'(TABLE_ENTRIES);
  assign scan_addr = base + EAW'(idx);
  assign user_addr = base + EAW'(q_ri[IW-1:0]);
  assign new_addr  = base + EAW'(sel_fill[IW-1:0]);
  assign ent_raddr = cmd.ent_rd_user ? user_addr : scan_addr;
  assign ent_waddr = cmd.ent_wr_hit ? scan_addr : new_addr;
  assign ent_we    = cmd.ent_wr_hit | cmd.ent_wr_new;

  assign rd_al   = ent_rdata[68:64];
  assign rd_key  = ent_rdata[63:32];
  assign rd_cnt  = ent_rdata[31:0];
  assign ent_inc = sat_inc(rd_cnt);
  assign ent_wdata = cmd.ent_wr_hit ? {rd_al, rd_key, ent_inc} : {al, kv, 32'd1};

  ifc_ram #(.WIDTH(EW), .DEPTH(ED)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  // scan status
  assign sts.match     = (rd_key == kv) && (rd_al == al);
  assign sts.last      = (FW'(idx) + FW'(1)) == sel_fill;
  assign sts.full      = (sel_fill == FW'(TABLE_ENTRIES));
  assign sts.fill_zero = (sel_fill == '0);

  always_comb begin
    if (q_rt == RT_OPCODES) begin
      rdnone_fill = extent;
    end else if (q_rt <= RT_STORES) begin
      rdnone_fill = fill9;
    end else begin
      rdnone_fill = 9'd0;
    end
  end

  // request latch and scan index
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_req <= req_type;
      q_op  <= opcode;
      q_key <= key_value;
      q_al  <= align_log2;
      q_off <= mem_offset;
      q_rt  <= read_table;
      q_ri  <= read_index;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end
  end

  // control state: config, extent, valid bits, fill levels
  always_ff @(posedge clk) begin
    if (rst) begin
      load_match  <= 8'd40;
      store_match <= 8'd54;
      extent      <= 9'd0;
      op_valid    <= '0;
      for (int i = 0; i < 6; i++) fill[i] <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index) store_match <= cfg_data;
        else           load_match  <= cfg_data;
      end
      if (cmd.op_wr) begin
        op_valid[op_addr] <= 1'b1;
        extent            <= ext_new;
      end
      if (cmd.ent_wr_new) begin
        fill[tbl] <= sel_fill + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      entry_valid <= 1'b0;
      first_key   <= 32'd0;
      second_key  <= 32'd0;
      hit_count   <= 32'd0;
      fill_level  <= 9'd0;
      case (cmd.out_sel)
        OUT_OPCNT: begin
          status     <= ext_grow ? ST_NEW : ST_HIT;
          first_key  <= 32'(q_op);
          hit_count  <= op_inc;
          fill_level <= ext_new;
        end
        OUT_HIT: begin
          status     <= ST_HIT;
          first_key  <= pair ? 32'(q_al) : q_key;
          second_key <= pair ? q_off : 32'd0;
          hit_count  <= ent_inc;
          fill_level <= fill9;
        end
        OUT_NEW: begin
          status     <= ST_NEW;
          first_key  <= pair ? 32'(q_al) : q_key;
          second_key <= pair ? q_off : 32'd0;
          hit_count  <= 32'd1;
          fill_level <= fill9 + 9'd1;
        end
        OUT_FULL: begin
          status     <= ST_FULL;
          first_key  <= pair ? 32'(q_al) : q_key;
          second_key <= pair ? q_off : 32'd0;
          fill_level <= fill9;
        end
        OUT_RDOP: begin
          status      <= ST_READ;
          entry_valid <= 1'b1;
          first_key   <= 32'(q_ri);
          hit_count   <= op_cur;
          fill_level  <= extent;
        end
        OUT_RDENT: begin
          status      <= ST_READ;
          entry_valid <= 1'b1;
          first_key   <= pair ? 32'(rd_al) : rd_key;
          second_key  <= pair ? rd_key : 32'd0;
          hit_count   <= rd_cnt;
          fill_level  <= fill9;
        end
        OUT_RDNONE: begin
          status     <= ST_READ;
          fill_level <= rdnone_fill;
        end
        default: status <= ST_IGNORED;
      endcase
    end
  end

endmodule

[hdl/instruction_frequency_counter.sv]
// Top level of the instruction frequency counter.
// Depends on ifc_pkg, ifc_ctrl, ifc_dpath and ifc_ram.
//
// One request at a time: a request is taken when start is high and busy low,
// and its result appears for one cycle with done high; the receiver cannot
// stall it, and a new request may be started in that same cycle. An opcode
// event or a histogram read passes through an evaluate state and then an
// update or read state; an ignored event or an out-of-range read is answered
// from the evaluate state. A key, load or store event scans its table one
// entry at a time through a single RAM read port with registered data, with
// a read state and a compare state per entry, ending in a miss state unless
// a hit is found. A table read passes through the evaluate and a read state.
// Configuration writes are always ready.
module instruction_frequency_counter import ifc_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int OPCODE_SLOTS  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [7:0]  opcode,
  input  logic [31:0] key_value,
  input  logic [4:0]  align_log2,
  input  logic [31:0] mem_offset,
  input  logic [2:0]  read_table,
  input  logic [7:0]  read_index,
  output logic        done,
  output logic [2:0]  status,
  output logic        entry_valid,
  output logic [31:0] first_key,
  output logic [31:0] second_key,
  output logic [31:0] hit_count,
  output logic [8:0]  fill_level
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ifc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ifc_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .OPCODE_SLOTS  (OPCODE_SLOTS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (req_type),
    .opcode      (opcode),
    .key_value   (key_value),
    .align_log2  (align_log2),
    .mem_offset  (mem_offset),
    .read_table  (read_table),
    .read_index  (read_index),
    .cmd         (cmd),
    .sts         (sts),
    .done        (done),
    .status      (status),
    .entry_valid (entry_valid),
    .first_key   (first_key),
    .second_key  (second_key),
    .hit_count   (hit_count),
    .fill_level  (fill_level)
  );

endmodule

[hdl/ifc_checker.sv]
// Port-level checks for the instruction frequency counter, bound to the top.
// Depends on assert_macros.svh and ifc_pkg.
`include "assert_macros.svh"

module ifc_checker import ifc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [2:0] status,
  input logic       entry_valid
);

  // accepted request keeps the block busy next cycle
  `ASSERT_NEXT(a_start_busy, start && !busy, busy)
  // a result only follows work in progress
  `ASSERT_IMPL(a_done_after_busy, done, $past(busy))
  // status codes stay in range
  `ASSERT_IMPL(a_status_range, done, status <= ST_READ)
  // only reads report a valid entry
  `ASSERT_IMPL(a_valid_on_read, done && entry_valid, status == ST_READ)

endmodule

bind instruction_frequency_counter ifc_checker u_ifc_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .entry_valid (entry_valid)
);

[bench/tb_instruction_frequency_counter.sv]
// Self-checking bench for instruction_frequency_counter: a directed table, then random
// event streams, checked against a predictor of the histogram and key tables.
// Depends on ifc_pkg and the instruction_frequency_counter RTL.
module tb_instruction_frequency_counter;
  import ifc_pkg::*;

  localparam int ENTRIES = 64;
  localparam int SLOTS   = 256;

  typedef struct {
    logic [2:0]  req;
    logic [7:0]  op;
    logic [31:0] key;
    logic [4:0]  al;
    logic [31:0] off;
    logic [2:0]  rt;
    logic [7:0]  ri;
  } event_t;

  typedef struct {
    logic [2:0]  st;
    logic        vld;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] cnt;
    logic [8:0]  fill;
  } outcome_t;

  typedef struct {
    event_t   ev;
    bit       typed;
    outcome_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  req_type = '0;
  logic [7:0]  opcode = '0;
  logic [31:0] key_value = '0;
  logic [4:0]  align_log2 = '0;
  logic [31:0] mem_offset = '0;
  logic [2:0]  read_table = '0;
  logic [7:0]  read_index = '0;
  logic        done;
  logic [2:0]  status;
  logic        entry_valid;
  logic [31:0] first_key;
  logic [31:0] second_key;
  logic [31:0] hit_count;
  logic [8:0]  fill_level;

  instruction_frequency_counter u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .start(start), .busy(busy),
    .req_type(req_type), .opcode(opcode), .key_value(key_value),
    .align_log2(align_log2), .mem_offset(mem_offset),
    .read_table(read_table), .read_index(read_index),
    .done(done), .status(status), .entry_valid(entry_valid),
    .first_key(first_key), .second_key(second_key),
    .hit_count(hit_count), .fill_level(fill_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: histogram, key tables in first-seen order, match registers
  logic [7:0]  load_match, store_match;
  logic [31:0] op_hist [SLOTS];
  logic [8:0]  op_extent;
  logic [31:0] single_key [4][ENTRIES];
  logic [4:0]  pair_align [2][ENTRIES];
  logic [31:0] pair_off [2][ENTRIES];
  logic [31:0] key_hits [6][ENTRIES];
  int          key_fill [6];

  outcome_t pending_results [$];
  int       n_errors = 0;
  int       idle_pct = 0;

  function automatic logic [31:0] bump(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic outcome_t mk_out(input logic [2:0] st, input logic vld,
                                      input logic [31:0] k1, input logic [31:0] k2,
                                      input logic [31:0] cnt, input logic [8:0] fill);
    outcome_t o;
    o.st = st; o.vld = vld; o.k1 = k1; o.k2 = k2; o.cnt = cnt; o.fill = fill;
    return o;
  endfunction

  function automatic event_t mk_ev(input logic [2:0] req, input logic [7:0] op,
                                   input logic [31:0] key, input logic [4:0] al,
                                   input logic [31:0] off, input logic [2:0] rt,
                                   input logic [7:0] ri);
    event_t e;
    e.req = req; e.op = op; e.key = key; e.al = al; e.off = off; e.rt = rt; e.ri = ri;
    return e;
  endfunction

  // hit, append or drop a key in table t (0..3 single, 4..5 pair)
  function automatic outcome_t tally_key(input int t, input logic [31:0] k1,
                                         input logic [31:0] k2);
    int  f;
    bit  hit;
    f = key_fill[t];
    for (int i = 0; i < f; i++) begin
      hit = (t >= 4) ? (pair_align[t-4][i] == k1[4:0] && pair_off[t-4][i] == k2)
                     : (single_key[t][i] == k1);
      if (hit) begin
        key_hits[t][i] = bump(key_hits[t][i]);
        return mk_out(ST_HIT, 1'b0, k1, k2, key_hits[t][i], 9'(f));
      end
    end
    if (f >= ENTRIES) return mk_out(ST_FULL, 1'b0, k1, k2, '0, 9'(f));
    if (t >= 4) begin
      pair_align[t-4][f] = k1[4:0];
      pair_off[t-4][f] = k2;
    end else begin
      single_key[t][f] = k1;
    end
    key_hits[t][f] = 32'd1;
    key_fill[t] = f + 1;
    return mk_out(ST_NEW, 1'b0, k1, k2, 32'd1, 9'(f + 1));
  endfunction

  // expected result of one accepted request
  function automatic outcome_t count_event(input event_t e);
    logic [2:0] st;
    int         t;
    case (e.req)
      REQ_OPCODE: begin
        st = ST_HIT;
        if (9'(e.op) >= op_extent) begin
          op_extent = 9'(e.op) + 9'd1;
          st = ST_NEW;
        end
        op_hist[e.op] = bump(op_hist[e.op]);
        return mk_out(st, 1'b0, 32'(e.op), '0, op_hist[e.op], op_extent);
      end
      REQ_CONST, REQ_LREAD, REQ_LWRITE, REQ_LTEE:
        return tally_key(int'(e.req) - 1, e.key, '0);
      REQ_LOAD:
        return (e.op == load_match) ? tally_key(4, 32'(e.al), e.off)
                                    : mk_out(ST_IGNORED, 1'b0, '0, '0, '0, '0);
      REQ_STORE:
        return (e.op == store_match) ? tally_key(5, 32'(e.al), e.off)
                                     : mk_out(ST_IGNORED, 1'b0, '0, '0, '0, '0);
      default: begin
        if (e.rt == RT_OPCODES) begin
          if (9'(e.ri) < op_extent)
            return mk_out(ST_READ, 1'b1, 32'(e.ri), '0, op_hist[e.ri], op_extent);
          return mk_out(ST_READ, 1'b0, '0, '0, '0, op_extent);
        end
        if (e.rt > RT_STORES) return mk_out(ST_READ, 1'b0, '0, '0, '0, '0);
        t = int'(e.rt) - 1;
        if (int'(e.ri) >= key_fill[t]) return mk_out(ST_READ, 1'b0, '0, '0, '0, 9'(key_fill[t]));
        if (t >= 4)
          return mk_out(ST_READ, 1'b1, 32'(pair_align[t-4][e.ri]), pair_off[t-4][e.ri],
                        key_hits[t][e.ri], 9'(key_fill[t]));
        return mk_out(ST_READ, 1'b1, single_key[t][e.ri], '0, key_hits[t][e.ri],
                      9'(key_fill[t]));
      end
    endcase
  endfunction

  // result checker: every done pulse is matched with the oldest expectation
  always @(posedge clk) begin
    outcome_t w;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        n_errors++;
      end else begin
        w = pending_results.pop_front();
        if (status !== w.st) begin
          $error("status: expected %0d, got %0d", w.st, status); n_errors++;
        end
        if (entry_valid !== w.vld) begin
          $error("entry_valid: expected %0d, got %0d", w.vld, entry_valid); n_errors++;
        end
        if (first_key !== w.k1) begin
          $error("first_key: expected %h, got %h", w.k1, first_key); n_errors++;
        end
        if (second_key !== w.k2) begin
          $error("second_key: expected %h, got %h", w.k2, second_key); n_errors++;
        end
        if (hit_count !== w.cnt) begin
          $error("hit_count: expected %h, got %h", w.cnt, hit_count); n_errors++;
        end
        if (fill_level !== w.fill) begin
          $error("fill_level: expected %0d, got %0d", w.fill, fill_level); n_errors++;
        end
      end
    end
  end

  // one request through the start/busy handshake; called just after a rising edge
  task automatic issue(input event_t e, input bit typed, input outcome_t want);
    outcome_t p;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req_type <= e.req; opcode <= e.op; key_value <= e.key; align_log2 <= e.al;
    mem_offset <= e.off; read_table <= e.rt; read_index <= e.ri;
    do @(posedge clk); while (busy);
    p = count_event(e);
    pending_results.push_back(typed ? want : p);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one register write; returns only after the write is taken and cfg_valid has dropped, so writes never overlap
  task automatic write_reg(input logic idx, input logic [7:0] v);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == 1'b0) load_match = v; else store_match = v;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    return ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 40));
  endfunction

  function automatic event_t random_event();
    event_t e;
    int     t;
    e = mk_ev(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), pick_key(),
              5'($urandom_range(0, 31)), pick_key(), 3'($urandom_range(0, 6)), '0);
    if (e.req == REQ_LOAD && $urandom_range(0, 9) < 8) e.op = load_match;
    if (e.req == REQ_STORE && $urandom_range(0, 9) < 8) e.op = store_match;
    if (e.req == REQ_LOAD || e.req == REQ_STORE) e.al = 5'($urandom_range(0, 3)) << $urandom_range(0, 3);
    if (e.req == REQ_READ) begin
      if ($urandom_range(0, 4) == 0) e.ri = 8'($urandom());
      else if (e.rt == RT_OPCODES) e.ri = 8'($urandom_range(0, int'(op_extent)));
      else begin
        t = int'(e.rt) - 1;
        e.ri = 8'($urandom_range(0, key_fill[t]));
      end
    end
    return e;
  endfunction

  plan_row_t plan [$];
  logic [7:0] load_set  [4] = '{8'd0, 8'd255, 8'd0, 8'd40};
  logic [7:0] store_set [4] = '{8'd255, 8'd0, 8'd0, 8'd54};
  int         pct_set   [4] = '{34, 48, 0, 0};

  initial begin
    outcome_t none;
    none = mk_out('0, '0, '0, '0, '0, '0);
    load_match = 8'd40; store_match = 8'd54; op_extent = '0;
    foreach (op_hist[i]) op_hist[i] = '0;
    foreach (key_fill[i]) key_fill[i] = 0;

    // directed rows: typed results where obvious, predictor elsewhere
    plan.push_back('{mk_ev(REQ_READ, 0, 0, 0, 0, RT_OPCODES, 0), 1,
                     mk_out(ST_READ, 0, 0, 0, 0, 0)});
    plan.push_back('{mk_ev(REQ_READ, 0, 0, 0, 0, RT_STORES, 8'd255), 1,
                     mk_out(ST_READ, 0, 0, 0, 0, 0)});
    plan.push_back('{mk_ev(REQ_READ, 0, 0, 0, 0, 3'd7, 8'd0), 1,
                     mk_out(ST_READ, 0, 0, 0, 0, 0)});
    plan.push_back('{mk_ev(REQ_OPCODE, 8'd255, 0, 0, 0, 0, 0), 1,
                     mk_out(ST_NEW, 0, 255, 0, 1, 256)});
    plan.push_back('{mk_ev(REQ_OPCODE, 8'd0, 0, 0, 0, 0, 0), 1,
                     mk_out(ST_HIT, 0, 0, 0, 1, 256)});
    plan.push_back('{mk_ev(REQ_OPCODE, 8'd255, 0, 0, 0, 0, 0), 1,
                     mk_out(ST_HIT, 0, 255, 0, 2, 256)});
    plan.push_back('{mk_ev(REQ_LOAD, 8'd0, 0, 5'd31, '1, 0, 0), 1,
                     mk_out(ST_IGNORED, 0, 0, 0, 0, 0)});
    plan.push_back('{mk_ev(REQ_STORE, 8'd255, 0, 5'd31, '1, 0, 0), 1,
                     mk_out(ST_IGNORED, 0, 0, 0, 0, 0)});
    plan.push_back('{mk_ev(REQ_LOAD, 8'd40, 0, 5'd31, '1, 0, 0), 1,
                     mk_out(ST_NEW, 0, 31, 32'hFFFF_FFFF, 1, 1)});
    plan.push_back('{mk_ev(REQ_LOAD, 8'd40, 0, 5'd31, '1, 0, 0), 0, none});
    plan.push_back('{mk_ev(REQ_LOAD, 8'd40, 0, 5'd0, '0, 0, 0), 0, none});
    plan.push_back('{mk_ev(REQ_STORE, 8'd54, 0, 5'd0, '0, 0, 0), 1,
                     mk_out(ST_NEW, 0, 0, 0, 1, 1)});
    plan.push_back('{mk_ev(REQ_CONST, 0, '1, 0, 0, 0, 0), 1,
                     mk_out(ST_NEW, 0, 32'hFFFF_FFFF, 0, 1, 1)});
    plan.push_back('{mk_ev(REQ_CONST, 0, '0, 0, 0, 0, 0), 0, none});
    plan.push_back('{mk_ev(REQ_CONST, 0, '1, 0, 0, 0, 0), 0, none});
    plan.push_back('{mk_ev(REQ_LREAD, 0, 32'd7, 0, 0, 0, 0), 0, none});
    plan.push_back('{mk_ev(REQ_LWRITE, 0, 32'd7, 0, 0, 0, 0), 0, none});
    plan.push_back('{mk_ev(REQ_LTEE, 0, 32'hA5A5_5A5A, 0, 0, 0, 0), 0, none});
    plan.push_back('{mk_ev(REQ_READ, 0, 0, 0, 0, RT_OPCODES, 8'd255), 0, none});
    plan.push_back('{mk_ev(REQ_READ, 0, 0, 0, 0, 3'd1, 8'd1), 0, none});
    plan.push_back('{mk_ev(REQ_READ, 0, 0, 0, 0, 3'd1, 8'd255), 1,
                     mk_out(ST_READ, 0, 0, 0, 0, 2)});
    plan.push_back('{mk_ev(REQ_READ, 0, 0, 0, 0, 3'd5, 8'd1), 0, none});
    plan.push_back('{mk_ev(REQ_READ, 0, 0, 0, 0, RT_STORES, 8'd0), 0, none});

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) issue(plan[i].ev, plan[i].typed, plan[i].want);

    // fill the tee table to capacity; the keys beyond it are dropped
    for (int i = 0; i < ENTRIES + 2; i++)
      issue(mk_ev(REQ_LTEE, 0, 32'h1000 + i, 0, 0, 0, 0), 0, none);
    issue(mk_ev(REQ_READ, 0, 0, 0, 0, 3'd4, 8'(ENTRIES - 1)), 0, none);

    // random phases under different match settings and idling
    for (int p = 0; p < 4; p++) begin
      drain();
      write_reg(1'b0, (p == 2) ? 8'($urandom()) : load_set[p]);
      write_reg(1'b1, (p == 2) ? 8'($urandom()) : store_set[p]);
      idle_pct = pct_set[p];
      for (int n = 0; n < 420; n++) issue(random_event(), 0, none);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (n_errors == 0 && pending_results.size() == 0)
      $display("tb_instruction_frequency_counter: clean");
    else
      $display("tb_instruction_frequency_counter: errors");
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("tb_instruction_frequency_counter: errors");
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/ifc_pkg.sv
hdl/ifc_ram.sv
hdl/ifc_ctrl.sv
hdl/ifc_dpath.sv
hdl/instruction_frequency_counter.sv
hdl/ifc_checker.sv
bench/tb_instruction_frequency_counter.sv
